// ----- src/ots_pkg.sv -----
// Shared constants, codes and control types for the subsampled Otsu threshold block.
package ots_pkg;

    // Gray levels and histogram bins
    localparam int GRAY_LEVELS = 256;
    localparam int GRAY_W      = 8;
    localparam int BIN_W       = 19;
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // Raster position and configuration widths
    localparam int DIM_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Sweep arithmetic widths (exact, no rounding)
    localparam int CNT_W   = 27;   // total count, up to 256 saturated bins
    localparam int SUM_W   = 35;   // weighted sum of levels
    localparam int N_W     = 20;   // width*height/4
    localparam int PROD0_W = 55;   // S0*N
    localparam int DIFF_W  = 62;   // |S0*N - S*C0|
    localparam int SQ_W    = 124;  // squared difference
    localparam int X_W     = 151;  // squared difference times opposite count
    localparam int NUM_W   = 152;  // score numerator
    localparam int DEN_W   = 54;   // score denominator C0*C1
    localparam int MUL_A_W = 152;
    localparam int MUL_B_W = 62;
    localparam int MUL_P_W = 206;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GRAY = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0]  WIDTH_RESET    = 11'd188;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET   = 11'd120;
    localparam logic [GRAY_W-1:0] MIN_GRAY_RESET = 8'd100;

    // Multiply steps of one candidate evaluation, in issue order
    typedef enum logic [3:0] {
        STEP_A0   = 4'd0,   // S0*N
        STEP_B0   = 4'd1,   // S*C0, then lower difference
        STEP_A1   = 4'd2,   // S1*N
        STEP_B1   = 4'd3,   // S*C1, then upper difference
        STEP_D0SQ = 4'd4,
        STEP_X0   = 4'd5,   // lower square times C1
        STEP_D1SQ = 4'd6,
        STEP_X1   = 4'd7,   // upper square times C0, then numerator
        STEP_DEN  = 4'd8,   // C0*C1
        STEP_LHS  = 4'd9,   // candidate num times best den
        STEP_RHS  = 4'd10   // best num times candidate den, then compare
    } ots_step_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              sweep_init;
        logic              sum_acc;
        logic              upd;
        logic              hist_rd;
        logic              mul_start;
        logic              mul_store;
        logic              clear_hist;
        logic [GRAY_W-1:0] level;
        ots_step_t         step;
    } ots_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mul_done;
        logic qualify;
    } ots_stat_t;

endpackage

// ----- src/ots_hist.sv -----
// Histogram memory with per-bin valid bits, raster position and parity subsampling.
module ots_hist import ots_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pix_accept,
    input  logic [GRAY_W-1:0] pixel,
    input  logic              last,
    input  logic [CFG_W-1:0]  image_width,
    input  logic              sweep_rd,
    input  logic [GRAY_W-1:0] sweep_addr,
    input  logic              clear,
    output logic [BIN_W-1:0]  bin_value
);

    logic [BIN_W-1:0]       mem [GRAY_LEVELS];
    logic [GRAY_LEVELS-1:0] valid_reg;
    logic [DIM_W-1:0]       col_reg;
    logic [DIM_W-1:0]       row_reg;
    logic [BIN_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;
    logic                   inc_pend_reg;
    logic [GRAY_W-1:0]      inc_addr_reg;

    logic              sample;
    logic [GRAY_W-1:0] rd_addr;
    logic [BIN_W-1:0]  base;
    logic [BIN_W-1:0]  inc_value;
    logic [CFG_W-1:0]  col_plus;

    assign sample  = !col_reg[0] && !row_reg[0];
    assign rd_addr = sweep_rd ? sweep_addr : pixel;

    // Saturating increment of the registered bin read
    assign base      = rd_valid_reg ? rd_data_reg : '0;
    assign inc_value = (base == BIN_MAX) ? base : base + 1'b1;
    assign bin_value = base;

    // Bin storage: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (inc_pend_reg) begin
            mem[inc_addr_reg] <= inc_value;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
        inc_addr_reg <= pixel;
    end

    assign col_plus = {1'b0, col_reg} + 1'b1;

    // Valid bits and raster position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            inc_pend_reg <= 1'b0;
        end else begin
            inc_pend_reg <= pix_accept && sample;
            if (clear) begin
                valid_reg <= '0;
            end else if (inc_pend_reg) begin
                valid_reg[inc_addr_reg] <= 1'b1;
            end
            if (pix_accept) begin
                if (last) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (col_plus >= image_width) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_plus[DIM_W-1:0];
                end
            end
        end
    end

endmodule

// ----- src/ots_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
module ots_mul import ots_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a_in,
    input  logic [MUL_B_W-1:0] b_in,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    logic               busy_reg;
    logic [MUL_P_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_P_W-1:0] acc_reg;

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    // Operand shifting and accumulation
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= MUL_P_W'(a_in);
            b_reg   <= b_in;
            acc_reg <= '0;
        end else if (busy_reg && b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

// ----- src/ots_dpath.sv -----
// Datapath: configuration registers, histogram, sums and exact score comparison.
module ots_dpath import ots_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pix_accept,
    input  logic [GRAY_W-1:0]    pixel,
    input  logic                 last,
    input  ots_cmd_t             cmd,
    output ots_stat_t            stat,
    output logic [GRAY_W-1:0]    threshold
);

    logic [CFG_W-1:0]  image_width_reg;
    logic [CFG_W-1:0]  image_height_reg;
    logic [GRAY_W-1:0] min_gray_reg;
    logic [N_W-1:0]    n_reg;

    logic [CNT_W-1:0]   c_all_reg;
    logic [SUM_W-1:0]   s_all_reg;
    logic [CNT_W-1:0]   c0_reg;
    logic [SUM_W-1:0]   s0_reg;
    logic [PROD0_W-1:0] a_reg;
    logic [DIFF_W-1:0]  d0_reg;
    logic [DIFF_W-1:0]  d1_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [X_W-1:0]     x0_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [MUL_P_W-1:0] lhs_reg;
    logic [NUM_W-1:0]   best_num_reg;
    logic [DEN_W-1:0]   best_den_reg;
    logic [GRAY_W-1:0]  best_level_reg;

    logic [BIN_W-1:0]     bin_value;
    logic [2*CFG_W-1:0]   area;
    logic                 in_range;
    logic [CNT_W-1:0]     weighted;
    logic [CNT_W-1:0]     c1;
    logic [SUM_W-1:0]     s1;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_done;
    logic [MUL_P_W-1:0]   prod;
    logic [DIFF_W-1:0]    a_ext;
    logic [DIFF_W-1:0]    diff;

    ots_hist u_hist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix_accept  (pix_accept),
        .pixel       (pixel),
        .last        (last),
        .image_width (image_width_reg),
        .sweep_rd    (cmd.hist_rd),
        .sweep_addr  (cmd.level),
        .clear       (cmd.clear_hist),
        .bin_value   (bin_value)
    );

    ots_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .prod    (prod)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            min_gray_reg     <= MIN_GRAY_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:    image_width_reg  <= cfg_data;
                REG_HEIGHT:   image_height_reg <= cfg_data;
                REG_MIN_GRAY: min_gray_reg     <= cfg_data[GRAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Subsampled pixel count N
    assign area = image_width_reg * image_height_reg;
    always_ff @(posedge aclk) begin
        n_reg <= area[2*CFG_W-1:2];
    end

    assign in_range = cmd.level >= min_gray_reg;
    assign weighted = CNT_W'(cmd.level) * CNT_W'(bin_value);
    assign c1       = c_all_reg - c0_reg;
    assign s1       = s_all_reg - s0_reg;

    assign stat.mul_done = mul_done;
    assign stat.qualify  = (c0_reg != '0) && (c1 != '0);
    assign threshold     = best_level_reg;

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_A0:   begin mul_a = MUL_A_W'(s0_reg);       mul_b = MUL_B_W'(n_reg);        end
            STEP_B0:   begin mul_a = MUL_A_W'(s_all_reg);    mul_b = MUL_B_W'(c0_reg);       end
            STEP_A1:   begin mul_a = MUL_A_W'(s1);           mul_b = MUL_B_W'(n_reg);        end
            STEP_B1:   begin mul_a = MUL_A_W'(s_all_reg);    mul_b = MUL_B_W'(c1);           end
            STEP_D0SQ: begin mul_a = MUL_A_W'(d0_reg);       mul_b = d0_reg;                 end
            STEP_X0:   begin mul_a = MUL_A_W'(sq_reg);       mul_b = MUL_B_W'(c1);           end
            STEP_D1SQ: begin mul_a = MUL_A_W'(d1_reg);       mul_b = d1_reg;                 end
            STEP_X1:   begin mul_a = MUL_A_W'(sq_reg);       mul_b = MUL_B_W'(c0_reg);       end
            STEP_DEN:  begin mul_a = MUL_A_W'(c0_reg);       mul_b = MUL_B_W'(c1);           end
            STEP_LHS:  begin mul_a = num_reg;                mul_b = MUL_B_W'(best_den_reg); end
            STEP_RHS:  begin mul_a = best_num_reg;           mul_b = MUL_B_W'(den_reg);      end
            default: ;
        endcase
    end

    // Absolute difference against the stored first product
    assign a_ext = DIFF_W'(a_reg);
    assign diff  = (a_ext >= prod[DIFF_W-1:0]) ? a_ext - prod[DIFF_W-1:0]
                                               : prod[DIFF_W-1:0] - a_ext;

    // Sums, intermediate products and best candidate
    always_ff @(posedge aclk) begin
        if (cmd.sweep_init) begin
            c_all_reg      <= '0;
            s_all_reg      <= '0;
            c0_reg         <= '0;
            s0_reg         <= '0;
            best_num_reg   <= '0;
            best_den_reg   <= DEN_W'(1);
            best_level_reg <= '0;
        end
        if (cmd.sum_acc && in_range) begin
            c_all_reg <= c_all_reg + CNT_W'(bin_value);
            s_all_reg <= s_all_reg + SUM_W'(weighted);
        end
        if (cmd.upd && in_range) begin
            c0_reg <= c0_reg + CNT_W'(bin_value);
            s0_reg <= s0_reg + SUM_W'(weighted);
        end
        if (cmd.mul_store) begin
            case (cmd.step)
                STEP_A0, STEP_A1:     a_reg  <= prod[PROD0_W-1:0];
                STEP_B0:              d0_reg <= diff;
                STEP_B1:              d1_reg <= diff;
                STEP_D0SQ, STEP_D1SQ: sq_reg <= prod[SQ_W-1:0];
                STEP_X0:              x0_reg <= prod[X_W-1:0];
                STEP_X1:              num_reg <= NUM_W'(x0_reg) + NUM_W'(prod[X_W-1:0]);
                STEP_DEN:             den_reg <= prod[DEN_W-1:0];
                STEP_LHS:             lhs_reg <= prod;
                STEP_RHS: begin
                    if (lhs_reg > prod) begin
                        best_num_reg   <= num_reg;
                        best_den_reg   <= den_reg;
                        best_level_reg <= cmd.level;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- src/ots_ctrl.sv -----
// Controller: pixel intake, histogram sweep sequencing and result handshake.
module ots_ctrl import ots_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic      pix_accept,
    output ots_cmd_t  cmd,
    input  ots_stat_t stat
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_WAIT    = 10'b00_0000_0010,
        ST_SUM_RD  = 10'b00_0000_0100,
        ST_SUM_ACC = 10'b00_0000_1000,
        ST_RD      = 10'b00_0001_0000,
        ST_UPD     = 10'b00_0010_0000,
        ST_CHK     = 10'b00_0100_0000,
        ST_MGO     = 10'b00_1000_0000,
        ST_MWAIT   = 10'b01_0000_0000,
        ST_NEXT    = 10'b10_0000_0000
    } ots_state_t;

    ots_state_t        state_reg, state_next;
    logic [GRAY_W-1:0] level_reg, level_next;
    ots_step_t         step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    ots_step_t         step_succ;
    logic              level_last;

    assign s_tready   = (state_reg == ST_IDLE);
    assign pix_accept = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign level_last = (level_reg == GRAY_LEVELS[GRAY_W-1:0] - 1'b1);

    // Following multiply step
    always_comb begin
        case (step_reg)
            STEP_A0:   step_succ = STEP_B0;
            STEP_B0:   step_succ = STEP_A1;
            STEP_A1:   step_succ = STEP_B1;
            STEP_B1:   step_succ = STEP_D0SQ;
            STEP_D0SQ: step_succ = STEP_X0;
            STEP_X0:   step_succ = STEP_D1SQ;
            STEP_D1SQ: step_succ = STEP_X1;
            STEP_X1:   step_succ = STEP_DEN;
            STEP_DEN:  step_succ = STEP_LHS;
            default:   step_succ = STEP_RHS;
        endcase
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.level      = level_reg;
        cmd.step       = step_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (pix_accept && s_tlast) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // last bin write lands here; hold while the old result waits
                if (!out_valid_reg) begin
                    cmd.sweep_init = 1'b1;
                    level_next     = '0;
                    state_next     = ST_SUM_RD;
                end
            end
            ST_SUM_RD: begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                cmd.sum_acc = 1'b1;
                level_next  = level_reg + 1'b1;
                state_next  = level_last ? ST_RD : ST_SUM_RD;
            end
            ST_RD: begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // skip candidates with an empty side
                if (stat.qualify) begin
                    step_next  = STEP_A0;
                    state_next = ST_MGO;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_MGO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (stat.mul_done) begin
                    cmd.mul_store = 1'b1;
                    if (step_reg == STEP_RHS) begin
                        state_next = ST_NEXT;
                    end else begin
                        step_next  = step_succ;
                        state_next = ST_MGO;
                    end
                end
            end
            ST_NEXT: begin
                level_next = level_reg + 1'b1;
                if (level_last) begin
                    cmd.clear_hist = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            step_reg      <= STEP_A0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/otsu_threshold_subsampled.sv -----
// Pixels are taken one per cycle until the frame's last item, then intake stops for the sweep.
// From that accept it waits for the last bin write (held while an older threshold still waits),
// runs a totals pass over all 256 levels, then visits each level in turn and, for each level with
// both sides non-empty, runs 11 shift-add multiplies to compare its score against the best.
// The threshold item appears on m_tvalid at the sweep's end; the next frame's pixels are taken
// while it waits. Reset (synchronous, aresetn low) clears the histogram valid bits and registers.
module otsu_threshold_subsampled import ots_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] pixel
    input  logic                 s_tlast,    // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [7:0] threshold
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ots_cmd_t  cmd;
    ots_stat_t stat;
    logic      pix_accept;

    ots_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .pix_accept (pix_accept),
        .cmd        (cmd),
        .stat       (stat)
    );

    ots_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pixel      (s_tdata),
        .last       (s_tlast),
        .cmd        (cmd),
        .stat       (stat),
        .threshold  (m_tdata)
    );

endmodule
